// ===== design/sem_pkg.sv =====
package sem_pkg;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 12;
    localparam int ROW_W   = 12;
    localparam int OCOL_W  = 11;
    localparam int GRAD_W  = 11;
    localparam int SQ_W    = 21;
    localparam int ROOT_W  = 11;
    localparam int SLOTS   = 4;

    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [3:0] ROOT_TOP_BIT = 4'(ROOT_W - 1);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_RDWAIT = 8'b0000_0010,
        ST_UPDATE = 8'b0000_0100,
        ST_GRAD   = 8'b0000_1000,
        ST_SQR    = 8'b0001_0000,
        ST_ROOT   = 8'b0010_0000,
        ST_FIN    = 8'b0100_0000,
        ST_SEND   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic       accept;
        logic       update;
        logic       grad;
        logic       sqr;
        logic       root_step;
        logic       load_out;
        logic [1:0] slot;
        logic [3:0] bit_idx;
    } cmd_t;

    typedef struct packed {
        logic [SLOTS-1:0] mask;
    } status_t;

endpackage

// ===== design/sem_ram.sv =====
module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/sem_ctrl.sv =====
module sem_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  sem_pkg::status_t status,
    output sem_pkg::cmd_t    cmd
);

    sem_pkg::state_t state_reg, state_next;
    logic [1:0] slot_reg, slot_next;
    logic [3:0] bit_reg, bit_next;
    logic [1:0] first_slot;
    logic [1:0] after_slot;
    logic       after_any;

    always_comb begin
        first_slot = 2'd0;
        for (int i = sem_pkg::SLOTS - 1; i >= 0; i--) begin
            if (status.mask[i]) begin
                first_slot = 2'(i);
            end
        end
        after_slot = 2'd0;
        after_any  = 1'b0;
        for (int i = sem_pkg::SLOTS - 1; i >= 0; i--) begin
            if (status.mask[i] && (2'(i) > slot_reg)) begin
                after_slot = 2'(i);
                after_any  = 1'b1;
            end
        end
    end

    always_comb begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        bit_next      = bit_reg;
        cmd           = '0;
        cmd.slot      = slot_reg;
        cmd.bit_idx   = bit_reg;
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;
        unique case (state_reg)
            sem_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = sem_pkg::ST_RDWAIT;
                end
            end
            sem_pkg::ST_RDWAIT: begin
                state_next = sem_pkg::ST_UPDATE;
            end
            sem_pkg::ST_UPDATE: begin
                cmd.update = 1'b1;
                slot_next  = first_slot;
                state_next = (|status.mask) ? sem_pkg::ST_GRAD : sem_pkg::ST_IDLE;
            end
            sem_pkg::ST_GRAD: begin
                cmd.grad   = 1'b1;
                state_next = sem_pkg::ST_SQR;
            end
            sem_pkg::ST_SQR: begin
                cmd.sqr    = 1'b1;
                bit_next   = sem_pkg::ROOT_TOP_BIT;
                state_next = sem_pkg::ST_ROOT;
            end
            sem_pkg::ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (bit_reg == 4'd0) begin
                    state_next = sem_pkg::ST_FIN;
                end else begin
                    bit_next = bit_reg - 4'd1;
                end
            end
            sem_pkg::ST_FIN: begin
                cmd.load_out = 1'b1;
                state_next   = sem_pkg::ST_SEND;
            end
            sem_pkg::ST_SEND: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (after_any) begin
                        slot_next  = after_slot;
                        state_next = sem_pkg::ST_GRAD;
                    end else begin
                        state_next = sem_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = sem_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sem_pkg::ST_IDLE;
            slot_reg  <= 2'd0;
            bit_reg   <= 4'd0;
        end else begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            bit_reg   <= bit_next;
        end
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("Input taken while a word is offered.");

    a_accept_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == sem_pkg::ST_RDWAIT))
        else $error("Accepted pixel did not start a line read.");

    a_send_after_root: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == sem_pkg::ST_FIN))
        else $error("Result offered before the root finished.");

endmodule

// ===== design/sem_datapath.sv =====
module sem_datapath #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic                              cfg_addr,
    input  logic [sem_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [sem_pkg::PIX_W-1:0]         pixel_value,
    input  sem_pkg::cmd_t                     cmd,
    output sem_pkg::status_t                  status,
    output logic [sem_pkg::PIX_W-1:0]         edge_magnitude,
    output logic [sem_pkg::OCOL_W-1:0]        out_column,
    output logic [sem_pkg::ROW_W-1:0]         out_row,
    output logic                              last_in_run
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = (CW + 1 > sem_pkg::CFG_W + 1) ? CW + 1 : sem_pkg::CFG_W + 1;
    localparam int OCW  = (CW > sem_pkg::OCOL_W) ? CW : sem_pkg::OCOL_W;
    localparam logic [CMPW-1:0] MAX_W_C = CMPW'(MAX_WIDTH);

    logic [sem_pkg::CFG_W-1:0]  width_reg, height_reg;
    logic [CW-1:0]              col_cnt_reg;
    logic [sem_pkg::ROW_W-1:0]  row_cnt_reg;
    logic [CW-1:0]              cur_c_reg;
    logic [sem_pkg::ROW_W-1:0]  cur_r_reg;
    logic [sem_pkg::PIX_W-1:0]  pix_reg;
    logic [3:0]                 mask_reg;
    logic [sem_pkg::PIX_W-1:0]  win_reg [3][3];
    logic signed [sem_pkg::GRAD_W-1:0] gx_reg, gy_reg;
    logic [sem_pkg::SQ_W-1:0]   sq_reg;
    logic [sem_pkg::ROOT_W-1:0] root_reg;

    logic [CMPW-1:0] w_eff, c_plus;
    logic [sem_pkg::ROW_W:0] h_eff, r_plus;
    logic row_end, last_row, c_ge1, r_ge1;
    logic [sem_pkg::PIX_W-1:0] old_q, new_q, top_pix, mid_pix;

    logic [1:0] cols [3];
    logic [1:0] rows [3];
    logic [9:0] p [3][3];
    logic signed [sem_pkg::GRAD_W-1:0] gx_c, gy_c;
    logic [9:0] ax, ay;
    logic [sem_pkg::ROOT_W-1:0] trial;
    logic [2*sem_pkg::ROOT_W-1:0] trial_sq;
    logic [OCW-1:0] col_ext;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = CMPW'(1);
        end else if (CMPW'(width_reg) > MAX_W_C) begin
            w_eff = MAX_W_C;
        end else begin
            w_eff = CMPW'(width_reg);
        end
        h_eff    = (height_reg == '0) ? 13'd1 : {1'b0, height_reg};
        c_plus   = CMPW'(col_cnt_reg) + CMPW'(1);
        r_plus   = {1'b0, row_cnt_reg} + 13'd1;
        row_end  = c_plus >= w_eff;
        last_row = r_plus >= h_eff;
        c_ge1    = col_cnt_reg != '0;
        r_ge1    = row_cnt_reg != '0;
    end

    sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_older (
        .aclk  (aclk),
        .we    (cmd.update),
        .waddr (cur_c_reg),
        .wdata (new_q),
        .re    (cmd.accept),
        .raddr (col_cnt_reg),
        .rdata (old_q)
    );

    sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
        .aclk  (aclk),
        .we    (cmd.update),
        .waddr (cur_c_reg),
        .wdata (pix_reg),
        .re    (cmd.accept),
        .raddr (col_cnt_reg),
        .rdata (new_q)
    );

    always_comb begin
        top_pix = (cur_r_reg >= 12'd2) ? old_q : ((cur_r_reg != '0) ? new_q : pix_reg);
        mid_pix = (cur_r_reg != '0) ? new_q : pix_reg;
    end

    always_comb begin
        if (!cmd.slot[0]) begin
            cols[0] = (cur_c_reg == CW'(1)) ? 2'd1 : 2'd0;
            cols[1] = 2'd1;
        end else begin
            cols[0] = (cur_c_reg == '0) ? 2'd2 : 2'd1;
            cols[1] = 2'd2;
        end
        cols[2] = 2'd2;
        if (cmd.slot[1]) begin
            rows[0] = 2'd1;
            rows[1] = 2'd2;
        end else begin
            rows[0] = 2'd0;
            rows[1] = 2'd1;
        end
        rows[2] = 2'd2;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                p[i][j] = 10'(win_reg[cols[i]][rows[j]]);
            end
        end
        gx_c = $signed({1'b0, p[0][0] + (p[0][1] << 1) + p[0][2]})
             - $signed({1'b0, p[2][0] + (p[2][1] << 1) + p[2][2]});
        gy_c = $signed({1'b0, p[0][0] + (p[1][0] << 1) + p[2][0]})
             - $signed({1'b0, p[0][2] + (p[1][2] << 1) + p[2][2]});
        ax = gx_reg[sem_pkg::GRAD_W-1] ? 10'(-gx_reg) : 10'(gx_reg);
        ay = gy_reg[sem_pkg::GRAD_W-1] ? 10'(-gy_reg) : 10'(gy_reg);
        trial    = root_reg | (sem_pkg::ROOT_W'(1) << cmd.bit_idx);
        trial_sq = trial * trial;
        col_ext  = cmd.slot[0] ? OCW'(cur_c_reg) : OCW'(cur_c_reg) - OCW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= 12'd512;
            height_reg  <= 12'd512;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            mask_reg    <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    sem_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                    sem_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (cmd.accept) begin
                mask_reg <= {last_row & row_end, last_row & c_ge1,
                             r_ge1 & row_end, r_ge1 & c_ge1};
                if (row_end) begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= last_row ? '0 : r_plus[sem_pkg::ROW_W-1:0];
                end else begin
                    col_cnt_reg <= c_plus[CW-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pix_reg   <= pixel_value;
            cur_c_reg <= col_cnt_reg;
            cur_r_reg <= row_cnt_reg;
        end
        if (cmd.update) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2][0] <= top_pix;
            win_reg[2][1] <= mid_pix;
            win_reg[2][2] <= pix_reg;
        end
        if (cmd.grad) begin
            gx_reg <= gx_c;
            gy_reg <= gy_c;
        end
        if (cmd.sqr) begin
            sq_reg   <= sem_pkg::SQ_W'(ax * ax) + sem_pkg::SQ_W'(ay * ay);
            root_reg <= '0;
        end
        if (cmd.root_step && (trial_sq <= 22'(sq_reg))) begin
            root_reg <= trial;
        end
        if (cmd.load_out) begin
            edge_magnitude <= (root_reg > 11'd255) ? 8'd255 : root_reg[7:0];
            out_column     <= col_ext[sem_pkg::OCOL_W-1:0];
            out_row        <= cmd.slot[1] ? cur_r_reg : cur_r_reg - 12'd1;
            last_in_run    <= ~|(mask_reg & 4'(4'b1110 << cmd.slot));
        end
    end

    assign status.mask = mask_reg;

endmodule

// ===== design/sobel_edge_magnitude.sv =====
// Streaming 3x3 Sobel edge magnitude on 8-bit grey pixels in raster order. Each accepted
// pixel produces zero to four result words: the pixel one row up and one column left, plus
// the row-end column and the last row when those borders are reached, with replicated
// border pixels; tlast marks the final word caused by a pixel. One pixel is handled at a
// time: a pixel waits on a line store read and window update; each result word passes
// the gradient, squaring and 11-step one-bit-per-cycle square root unit, then waits for
// m_tready. Write image_width (index 0) and image_height (index 1) only while idle.
module sobel_edge_magnitude #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [11:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] edge_magnitude, [18:8] out_column, [30:19] out_row
    output logic        m_tlast
);

    sem_pkg::cmd_t    cmd;
    sem_pkg::status_t status;
    logic [7:0]  mag;
    logic [10:0] ocol;
    logic [11:0] orow;

    sem_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sem_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .pixel_value    (s_tdata),
        .cmd            (cmd),
        .status         (status),
        .edge_magnitude (mag),
        .out_column     (ocol),
        .out_row        (orow),
        .last_in_run    (m_tlast)
    );

    assign m_tdata = {1'b0, orow, ocol, mag};

endmodule

// ===== tb/sobel_edge_magnitude_tb.sv =====
`timescale 1ns / 1ps

module sobel_edge_magnitude_tb;

    localparam int MAXW = 2048;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [7:0]  mag;
        logic [10:0] col;
        logic [11:0] row;
        logic        last;
    } edge_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [11:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    sobel_edge_magnitude i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    logic [11:0] width_reg, height_reg;
    logic [7:0]  line_old [MAXW];
    logic [7:0]  line_new [MAXW];
    logic [7:0]  win [9];
    int unsigned col_cnt, row_cnt;

    logic [7:0]  pixel_q[$];
    edge_word_t  expected_q[$];
    int          errors = 0;
    int          idle_cycles = 0;
    logic        timed_out = 1'b0;

    function automatic int unsigned int_sqrt(int unsigned v);
        int unsigned res, b;
        res = 0;
        b = 32'h4000_0000;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [7:0] sobel_mag(int l, int m, int rr, int t, int md, int b);
        int p[3][3];
        int cs[3], rs[3];
        int gx, gy;
        int unsigned q;
        cs = '{l, m, rr};
        rs = '{t, md, b};
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                p[i][j] = win[cs[i] * 3 + rs[j]];
        gx = (p[0][0] + 2 * p[0][1] + p[0][2]) - (p[2][0] + 2 * p[2][1] + p[2][2]);
        gy = (p[0][0] + 2 * p[1][0] + p[2][0]) - (p[0][2] + 2 * p[1][2] + p[2][2]);
        q = int_sqrt(gx * gx + gy * gy);
        return q > 255 ? 8'd255 : q[7:0];
    endfunction

    task automatic predict_edges(logic [7:0] cur);
        int unsigned w, h, c, r, orow;
        logic [7:0] top, mid, ov, nv;
        bit row_end, last_row;
        edge_word_t words[$];
        edge_word_t e;
        int t, md, b;
        w = (width_reg == 0) ? 1 : width_reg;
        h = (height_reg == 0) ? 1 : height_reg;
        if (w > MAXW) w = MAXW;
        c = col_cnt;
        r = row_cnt;
        row_end = (c + 1 >= w);
        last_row = (r + 1 >= h);
        ov = line_old[c];
        nv = line_new[c];
        top = r >= 2 ? ov : (r >= 1 ? nv : cur);
        mid = r >= 1 ? nv : cur;
        for (int i = 0; i < 6; i++) win[i] = win[i + 3];
        win[6] = top;
        win[7] = mid;
        win[8] = cur;
        line_old[c] = nv;
        line_new[c] = cur;
        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 0 && r < 1) continue;
            if (pass == 1 && !last_row) continue;
            if (pass == 0) begin
                orow = r - 1; t = 0; md = 1; b = 2;
            end else begin
                orow = r; t = 1; md = 2; b = 2;
            end
            if (c >= 1) begin
                e.mag = sobel_mag((c == 1) ? 1 : 0, 1, 2, t, md, b);
                e.col = 11'(c - 1);
                e.row = 12'(orow);
                e.last = 1'b0;
                words.insert(words.size(), e);
            end
            if (row_end) begin
                e.mag = sobel_mag((c == 0) ? 2 : 1, 2, 2, t, md, b);
                e.col = 11'(c);
                e.row = 12'(orow);
                e.last = 1'b0;
                words.insert(words.size(), e);
            end
        end
        foreach (words[k]) begin
            words[k].last = (k == words.size() - 1);
            expected_q.insert(expected_q.size(), words[k]);
        end
        if (row_end) begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
        end
    endtask

    // The handshake is sampled at the rising edge and latched for the driver.
    logic s_fire, m_fire;
    always @(posedge aclk) begin
        s_fire <= s_tvalid && s_tready;
        m_fire <= m_tvalid && m_tready;
    end

    // Driver: the prediction is made when a word is accepted.
    int s_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_fire) begin
                predict_edges(s_tdata);
                void'(pixel_q.pop_front());
                s_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0;
            end
            if (s_fire || !s_tvalid) begin
                if (pixel_q.size() > 0 && s_gap == 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pixel_q[0];
                end else begin
                    s_tvalid <= 1'b0;
                    if (s_gap > 0) s_gap--;
                end
            end
        end
    end

    int m_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_fire) m_gap = $urandom_range(0, 2) == 0 ? $urandom_range(0, 18) : 0;
            if (m_gap > 0) begin
                m_tready <= 1'b0;
                m_gap--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        edge_word_t got, exp_w;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                got.mag = m_tdata[7:0];
                got.col = m_tdata[18:8];
                got.row = m_tdata[30:19];
                got.last = m_tlast;
                if (expected_q.size() == 0) begin
                    $display("%0t unexpected word: actual %h", $time, got);
                    errors++;
                end else begin
                    exp_w = expected_q.pop_front();
                    if (got.mag !== exp_w.mag || got.col !== exp_w.col
                        || got.row !== exp_w.row || got.last !== exp_w.last) begin
                        $display({"%0t mismatch: expected mag %0d col %0d row %0d last %0d,",
                                  " actual mag %0d col %0d row %0d last %0d"},
                                 $time, exp_w.mag, exp_w.col, exp_w.row, exp_w.last,
                                 got.mag, got.col, got.row, got.last);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (idle_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [11:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == sem_pkg::CFG_IMAGE_WIDTH) width_reg = val;
        else height_reg = val;
    endtask

    task automatic wait_drained();
        while (pixel_q.size() > 0 || s_tvalid || expected_q.size() > 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    // Feeds whole images so that every line entry read was written first.
    task automatic run_image(int w, int h, int mode);
        int n;
        write_reg(sem_pkg::CFG_IMAGE_WIDTH, 12'(w));
        write_reg(sem_pkg::CFG_IMAGE_HEIGHT, 12'(h));
        n = ((w == 0) ? 1 : (w > MAXW ? MAXW : w)) * ((h == 0) ? 1 : h);
        for (int i = 0; i < n; i++) begin
            case (mode)
                0: pixel_q.insert(pixel_q.size(), 8'($urandom));
                1: pixel_q.insert(pixel_q.size(),
                                  ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00);
                default: pixel_q.insert(pixel_q.size(), ((i % 2) != 0) ? 8'hFF : 8'h00);
            endcase
        end
        wait_drained();
    endtask

    initial begin
        int total;
        width_reg = 12'd512;
        height_reg = 12'd512;
        col_cnt = 0;
        row_cnt = 0;
        foreach (win[i]) win[i] = '0;
        foreach (line_old[i]) begin
            line_old[i] = '0;
            line_new[i] = '0;
        end
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // Directed: single pixel, zero sizes, one row, one column, random black-and-white 3x3.
        run_image(1, 1, 2);
        run_image(0, 0, 1);
        run_image(5, 1, 2);
        run_image(1, 4, 1);
        run_image(3, 3, 1);
        total = 20;
        while (total < 450) begin
            int w, h;
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            run_image(w, h, $urandom_range(0, 3) == 0 ? 1 : 0);
            total += w * h;
        end
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
design/sem_pkg.sv
design/sem_ram.sv
design/sem_ctrl.sv
design/sem_datapath.sv
design/sobel_edge_magnitude.sv
tb/sobel_edge_magnitude_tb.sv
